>>> hw/rtl/ecmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_pkg
// Shared types, codes and motor patterns for the encoder move controller.
// ----------------------------------------------------------------------------
package ecmc_pkg;

  // Field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned KindW   = 3;
  localparam int unsigned AmountW = 15;
  localparam int unsigned TargetW = 13;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MotorW  = 4;

  // Byte-padded word widths
  localparam int unsigned InDataW  = 24;  // kind + amount, padded
  localparam int unsigned OutDataW = 8;   // motor + busy + done, padded

  // Saturation limits
  localparam logic [TargetW-1:0] TargetMax = {TargetW{1'b1}};
  localparam logic [CountW-1:0]  CountMax  = {CountW{1'b1}};

  // Reciprocal of 5: floor(x * Recip5 / 2^Recip5Shift) == x / 5 for 15-bit x
  localparam int unsigned RecipW      = 16;
  localparam int unsigned Recip5Shift = 18;
  localparam logic [RecipW-1:0] Recip5 = 16'd52429;

  // What an input word carries
  typedef enum logic [ActionW-1:0] {
    ACT_MOVE  = 2'd0,
    ACT_LEFT  = 2'd1,
    ACT_RIGHT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Move kinds; the code above stop is treated as stop
  typedef enum logic [KindW-1:0] {
    KIND_FWD    = 3'd0,
    KIND_BWD    = 3'd1,
    KIND_SOFT_R = 3'd2,
    KIND_SOFT_L = 3'd3,
    KIND_HARD_R = 3'd4,
    KIND_HARD_L = 3'd5,
    KIND_STOP   = 3'd6
  } kind_t;

  // Motor pin patterns
  localparam logic [MotorW-1:0] PatFwd   = 4'h6;
  localparam logic [MotorW-1:0] PatBwd   = 4'h9;
  localparam logic [MotorW-1:0] PatSoftR = 4'h2;
  localparam logic [MotorW-1:0] PatSoftL = 4'h4;
  localparam logic [MotorW-1:0] PatHardR = 4'hA;
  localparam logic [MotorW-1:0] PatHardL = 4'h5;
  localparam logic [MotorW-1:0] PatStop  = 4'h0;

  // Registered input word
  typedef struct packed {
    action_t              action;
    logic [KindW-1:0]     move_kind;
    logic [AmountW-1:0]   amount;
  } item_t;

  // Motor pattern for a kind
  function automatic logic [MotorW-1:0] drive_pattern(input kind_t kind);
    logic [MotorW-1:0] pat;
    case (kind)
      KIND_FWD:    pat = PatFwd;
      KIND_BWD:    pat = PatBwd;
      KIND_SOFT_R: pat = PatSoftR;
      KIND_SOFT_L: pat = PatSoftL;
      KIND_HARD_R: pat = PatHardR;
      KIND_HARD_L: pat = PatHardL;
      default:     pat = PatStop;
    endcase
    return pat;
  endfunction

endpackage

>>> hw/rtl/ecmc_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecmc_target
// Pulse target for a move command: distance / 5, soft angle / 2,
// hard angle / 4, zero for stop; saturated to the target width.
// ----------------------------------------------------------------------------
module ecmc_target (
  input  ecmc_pkg::kind_t                   kind,
  input  logic [ecmc_pkg::AmountW-1:0]      amount,
  output logic [ecmc_pkg::TargetW-1:0]      target
);

  localparam int unsigned ProdW = ecmc_pkg::AmountW + ecmc_pkg::RecipW;

  logic [ProdW-1:0]                 prod5;
  logic [ecmc_pkg::TargetW-1:0]     div5;
  logic [ecmc_pkg::AmountW-2:0]     div2;
  logic [ecmc_pkg::TargetW-1:0]     div4;

  // Divide by the constants
  assign prod5 = ProdW'(amount) * ProdW'(ecmc_pkg::Recip5);
  assign div5  = prod5[ecmc_pkg::Recip5Shift +: ecmc_pkg::TargetW];
  assign div2  = amount[ecmc_pkg::AmountW-1:1];
  assign div4  = amount[ecmc_pkg::AmountW-1:2];

  // Select by kind; saturate the half-angle case
  always_comb begin
    case (kind)
      ecmc_pkg::KIND_FWD,
      ecmc_pkg::KIND_BWD: begin
        target = div5;
      end
      ecmc_pkg::KIND_SOFT_R,
      ecmc_pkg::KIND_SOFT_L: begin
        if (div2 > (ecmc_pkg::AmountW-1)'(ecmc_pkg::TargetMax)) begin
          target = ecmc_pkg::TargetMax;
        end else begin
          target = div2[ecmc_pkg::TargetW-1:0];
        end
      end
      ecmc_pkg::KIND_HARD_R,
      ecmc_pkg::KIND_HARD_L: begin
        target = div4;
      end
      default: begin
        target = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/encoder_counted_move_controller_core.sv
`timescale 1ns / 1ps
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle without back-pressure; both registers run back to back.
// Reset (rst, synchronous, active high): both pulse counts and the target
// clear, the move is stopped (kind stop, not moving), both word registers empty.
// Every input word yields exactly one result word.
// ----------------------------------------------------------------------------
// encoder_counted_move_controller_core
// Move commands set a pulse target; wheel encoder pulses count toward it.
// Drives the motor pattern while moving and flags done when the move ends.
// ----------------------------------------------------------------------------
module encoder_counted_move_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  // Input words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ecmc_pkg::InDataW-1:0]      s_axis_tdata,   // [2:0] move_kind, [17:3] amount
  input  logic [ecmc_pkg::ActionW-1:0]      s_axis_tuser,   // [1:0] action
  // Result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ecmc_pkg::OutDataW-1:0]     m_axis_tdata    // [3:0] motor_pattern,
                                                            // [4] busy_res, [5] done_res
);

  localparam int unsigned KindLo   = 0;
  localparam int unsigned AmountLo = ecmc_pkg::KindW;
  localparam int unsigned ResW     = ecmc_pkg::MotorW + 2;

  // Word registers
  logic                              in_valid;
  ecmc_pkg::item_t                   in_item;
  logic                              out_valid;
  logic [ResW-1:0]                   out_res;
  logic                              advance;

  // Move state
  logic [ecmc_pkg::CountW-1:0]       left_pulses;
  logic [ecmc_pkg::CountW-1:0]       right_pulses;
  logic [ecmc_pkg::TargetW-1:0]      target_pulses;
  ecmc_pkg::kind_t                   active_kind;
  logic                              moving;

  logic [ecmc_pkg::CountW-1:0]       left_pulses_next;
  logic [ecmc_pkg::CountW-1:0]       right_pulses_next;
  logic [ecmc_pkg::TargetW-1:0]      target_pulses_next;
  ecmc_pkg::kind_t                   active_kind_next;
  logic                              moving_next;
  logic                              done_next;

  ecmc_pkg::kind_t                   cmd_kind;
  logic [ecmc_pkg::TargetW-1:0]      cmd_target;
  logic [ecmc_pkg::CountW-1:0]       target_wide;
  logic [ecmc_pkg::CountW-1:0]       left_bumped;
  logic [ecmc_pkg::CountW-1:0]       right_bumped;
  logic                              left_hit;
  logic                              right_hit;
  logic                              hit;
  logic [ecmc_pkg::MotorW-1:0]       motor_next;

  // Move one word forward when the result register is free or drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Capture input word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.action    <= ecmc_pkg::action_t'(s_axis_tuser);
      in_item.move_kind <= s_axis_tdata[KindLo +: ecmc_pkg::KindW];
      in_item.amount    <= s_axis_tdata[AmountLo +: ecmc_pkg::AmountW];
    end
  end

  // Clamp the unused kind code to stop
  always_comb begin
    if (in_item.move_kind > ecmc_pkg::KindW'(ecmc_pkg::KIND_STOP)) begin
      cmd_kind = ecmc_pkg::KIND_STOP;
    end else begin
      cmd_kind = ecmc_pkg::kind_t'(in_item.move_kind);
    end
  end

  ecmc_target u_target (
    .kind   (cmd_kind),
    .amount (in_item.amount),
    .target (cmd_target)
  );

  // Advance the pulsed wheel's count, saturating at the top
  assign left_bumped  = (in_item.action == ecmc_pkg::ACT_LEFT &&
                         left_pulses != ecmc_pkg::CountMax) ? left_pulses + 1'b1
                                                            : left_pulses;
  assign right_bumped = (in_item.action == ecmc_pkg::ACT_RIGHT &&
                         right_pulses != ecmc_pkg::CountMax) ? right_pulses + 1'b1
                                                             : right_pulses;

  // Target reached on the counts after this pulse
  assign target_wide = ecmc_pkg::CountW'(target_pulses);
  assign left_hit    = left_bumped >= target_wide;
  assign right_hit   = right_bumped >= target_wide;

  always_comb begin
    case (active_kind)
      ecmc_pkg::KIND_SOFT_L: hit = right_hit;
      ecmc_pkg::KIND_HARD_R,
      ecmc_pkg::KIND_HARD_L: hit = left_hit || right_hit;
      default:               hit = left_hit;
    endcase
  end

  // Next move state for the word in the input register
  always_comb begin
    left_pulses_next   = left_pulses;
    right_pulses_next  = right_pulses;
    target_pulses_next = target_pulses;
    active_kind_next   = active_kind;
    moving_next        = moving;
    done_next          = 1'b0;
    case (in_item.action)
      ecmc_pkg::ACT_MOVE: begin
        left_pulses_next  = '0;
        right_pulses_next = '0;
        if (cmd_kind == ecmc_pkg::KIND_STOP || cmd_target == '0) begin
          target_pulses_next = '0;
          active_kind_next   = ecmc_pkg::KIND_STOP;
          moving_next        = 1'b0;
          done_next          = 1'b1;
        end else begin
          target_pulses_next = cmd_target;
          active_kind_next   = cmd_kind;
          moving_next        = 1'b1;
        end
      end
      ecmc_pkg::ACT_LEFT: begin
        left_pulses_next = left_bumped;
        if (moving && hit) begin
          active_kind_next = ecmc_pkg::KIND_STOP;
          moving_next      = 1'b0;
          done_next        = 1'b1;
        end
      end
      ecmc_pkg::ACT_RIGHT: begin
        right_pulses_next = right_bumped;
        if (moving && hit) begin
          active_kind_next = ecmc_pkg::KIND_STOP;
          moving_next      = 1'b0;
          done_next        = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  assign motor_next = moving_next ? ecmc_pkg::drive_pattern(active_kind_next)
                                  : ecmc_pkg::PatStop;

  // Commit state on each advanced word
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pulses   <= '0;
      right_pulses  <= '0;
      target_pulses <= '0;
      active_kind   <= ecmc_pkg::KIND_STOP;
      moving        <= 1'b0;
    end else if (advance) begin
      left_pulses   <= left_pulses_next;
      right_pulses  <= right_pulses_next;
      target_pulses <= target_pulses_next;
      active_kind   <= active_kind_next;
      moving        <= moving_next;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= {done_next, moving_next, motor_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(ecmc_pkg::OutDataW-ResW)'(0), out_res};

endmodule
